@@ design/sfc_pkg.sv @@
// Shared types and constants for the supervision frame checker.
// No dependencies; the register block and the top level import it.
package sfc_pkg;

    // Verdict codes
    localparam logic [1:0] KIND_ERROR  = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // Byte positions within a reply
    localparam logic [2:0] POS_OPEN    = 3'd0;
    localparam logic [2:0] POS_ADDR    = 3'd1;
    localparam logic [2:0] POS_CTRL    = 3'd2;
    localparam logic [2:0] POS_HCHK    = 3'd3;
    localparam logic [2:0] POS_CLOSE   = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_FLAG         = 3'd0;
    localparam logic [2:0] REG_ADDRESS      = 3'd1;
    localparam logic [2:0] REG_ACK          = 3'd2;
    localparam logic [2:0] REG_READY_EVEN   = 3'd3;
    localparam logic [2:0] REG_READY_ODD    = 3'd4;
    localparam logic [2:0] REG_REJECT_EVEN  = 3'd5;
    localparam logic [2:0] REG_REJECT_ODD   = 3'd6;
    localparam logic [2:0] REG_PARITY       = 3'd7;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register file contents
    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] address_value;
        logic [7:0] ack_code;
        logic [7:0] ready_even_code;
        logic [7:0] ready_odd_code;
        logic [7:0] reject_even_code;
        logic [7:0] reject_odd_code;
        logic       expected_parity;
    } t_cfg;

endpackage

@@ design/supervision_frame_checker_unit.sv @@
// Supervision frame checker: one byte word per cycle in unless input stalls, one verdict per reply.
// Latency: a verdict is registered at the edge that accepts the closing byte.
// Throughput: one byte per cycle while the output register is empty or being taken;
// input stalls whenever that register holds a verdict that is not taken.
// Reset (synchronous, active low) restores register defaults and byte position 0.
module supervision_frame_checker_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] rx_byte
    // master side
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [7:0]                  o_m_tdata,   // [1:0] reply_kind, [7:2] zero
    // configuration
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sfc_pkg::PADDR_W-1:0] i_paddr,
    input  logic [sfc_pkg::PDATA_W-1:0] i_pwdata,
    output logic [sfc_pkg::PDATA_W-1:0] o_prdata,
    output logic                        o_pready
);
    import sfc_pkg::*;

    t_cfg       cfg;
    logic [2:0] r_pos;
    logic       r_failed;
    logic [7:0] r_saved_addr;
    logic [7:0] r_saved_ctrl;
    logic [1:0] r_pending;
    logic       r_out_valid;
    logic [1:0] r_out_kind;

    logic       in_fire;
    logic       fail_now;
    logic [1:0] ctrl_kind;
    logic       ctrl_match;
    logic [7:0] rr_code;
    logic [7:0] rj_code;
    logic [7:0] rx;

    sfc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    assign rx         = i_s_tdata;
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_kind};

    // Classify the control byte: ack first, then ready, then reject
    always_comb begin
        rr_code    = cfg.expected_parity ? cfg.ready_odd_code  : cfg.ready_even_code;
        rj_code    = cfg.expected_parity ? cfg.reject_odd_code : cfg.reject_even_code;
        ctrl_match = 1'b1;
        if (rx == cfg.ack_code) begin
            ctrl_kind = KIND_ACK;
        end else if (rx == rr_code) begin
            ctrl_kind = KIND_ACCEPT;
        end else if (rx == rj_code) begin
            ctrl_kind = KIND_REJECT;
        end else begin
            ctrl_kind  = KIND_ERROR;
            ctrl_match = 1'b0;
        end
    end

    // Check the current word against its position
    always_comb begin
        unique case (r_pos)
            POS_OPEN:  fail_now = (rx != cfg.flag_value);
            POS_ADDR:  fail_now = (rx != cfg.address_value);
            POS_CTRL:  fail_now = !ctrl_match;
            POS_HCHK:  fail_now = (rx != (r_saved_addr ^ r_saved_ctrl));
            POS_CLOSE: fail_now = (rx != cfg.flag_value);
            default:   fail_now = 1'b0;
        endcase
    end

    // Advance group state and latch the verdict on the closing byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_OPEN;
            r_failed     <= 1'b0;
            r_pending    <= KIND_ERROR;
            r_saved_addr <= '0;
            r_saved_ctrl <= '0;
            r_out_valid  <= 1'b0;
            r_out_kind   <= KIND_ERROR;
        end else begin
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire) begin
                if (r_pos == POS_CLOSE) begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= (r_failed || fail_now) ? KIND_ERROR : r_pending;
                    r_pos       <= POS_OPEN;
                    r_failed    <= 1'b0;
                    r_pending   <= KIND_ERROR;
                end else begin
                    r_pos    <= r_pos + 3'd1;
                    r_failed <= r_failed || fail_now;
                    if (r_pos == POS_ADDR) begin
                        r_saved_addr <= rx;
                    end
                    if (r_pos == POS_CTRL) begin
                        r_saved_ctrl <= rx;
                        if (ctrl_match) begin
                            r_pending <= ctrl_kind;
                        end
                    end
                end
            end
        end
    end

    // Position never leaves the five-byte group
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CLOSE)
        else $error("byte position out of range");

    // A new verdict appears only after a closing byte was taken
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_fire && (r_pos == POS_CLOSE)))
        else $error("verdict without closing byte");

    // Group state clears after the closing byte
    a_group_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (r_pos == POS_CLOSE)) |=>
            (r_pos == POS_OPEN) && !r_failed && (r_pending == KIND_ERROR))
        else $error("group state not cleared");

endmodule

@@ design/sfc_regs.sv @@
// Configuration registers of the supervision frame checker, APB-style port.
// Depends on sfc_pkg for the register indexes and the t_cfg struct.
module sfc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [sfc_pkg::PADDR_W-1:0] i_paddr,
    input  logic [sfc_pkg::PDATA_W-1:0] i_pwdata,
    output logic [sfc_pkg::PDATA_W-1:0] o_prdata,
    output logic                        o_pready,
    output sfc_pkg::t_cfg               o_cfg
);
    import sfc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic [7:0] wbyte;

    assign o_pready = 1'b1;
    assign reg_idx  = i_paddr[PADDR_W-1:2];
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign wbyte    = i_pwdata[7:0];
    assign o_cfg    = r_cfg;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_value       <= 8'd126;
            r_cfg.address_value    <= 8'd1;
            r_cfg.ack_code         <= 8'd7;
            r_cfg.ready_even_code  <= 8'd5;
            r_cfg.ready_odd_code   <= 8'd133;
            r_cfg.reject_even_code <= 8'd1;
            r_cfg.reject_odd_code  <= 8'd129;
            r_cfg.expected_parity  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FLAG:        r_cfg.flag_value       <= wbyte;
                REG_ADDRESS:     r_cfg.address_value    <= wbyte;
                REG_ACK:         r_cfg.ack_code         <= wbyte;
                REG_READY_EVEN:  r_cfg.ready_even_code  <= wbyte;
                REG_READY_ODD:   r_cfg.ready_odd_code   <= wbyte;
                REG_REJECT_EVEN: r_cfg.reject_even_code <= wbyte;
                REG_REJECT_ODD:  r_cfg.reject_odd_code  <= wbyte;
                REG_PARITY:      r_cfg.expected_parity  <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_FLAG:        o_prdata[7:0] = r_cfg.flag_value;
            REG_ADDRESS:     o_prdata[7:0] = r_cfg.address_value;
            REG_ACK:         o_prdata[7:0] = r_cfg.ack_code;
            REG_READY_EVEN:  o_prdata[7:0] = r_cfg.ready_even_code;
            REG_READY_ODD:   o_prdata[7:0] = r_cfg.ready_odd_code;
            REG_REJECT_EVEN: o_prdata[7:0] = r_cfg.reject_even_code;
            REG_REJECT_ODD:  o_prdata[7:0] = r_cfg.reject_odd_code;
            REG_PARITY:      o_prdata[0]   = r_cfg.expected_parity;
            default: ;
        endcase
    end

endmodule
